FILE: design/sccr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sccr_pkg: shared types, constants and functions
// Request codes, controller/datapath command and status groups, and the
// sample-to-row conversion used by the scope capture column renderer.
// ----------------------------------------------------------------------------
package sccr_pkg;

    localparam int SCREEN_SIZE  = 240;
    localparam int ROW_OFFSET   = SCREEN_SIZE / 2;
    localparam int ROW_MAX      = SCREEN_SIZE - 1;
    localparam int DIV_SHIFT    = 5;
    localparam int DIV_ROUND    = (1 << DIV_SHIFT) - 1;
    localparam int COL_W        = 8;
    localparam int ROW_W        = 8;
    localparam int SAMPLE_W     = 16;
    localparam int CFG_W        = 10;
    localparam int LENGTH_RESET = 512;
    localparam int MOD_STEPS    = COL_W;

    typedef enum logic [1:0] {
        REQ_SAMPLE     = 2'd0,
        REQ_HOLD_BEGIN = 2'd1,
        REQ_HOLD_END   = 2'd2,
        REQ_QUERY      = 2'd3
    } req_type_t;

    typedef struct packed {
        logic clr_wr;
        logic smp_wr;
        logic set_hold;
        logic clr_hold;
        logic q_load;
        logic mod_step;
        logic addr_calc;
        logic rd_start;
        logic rd_stop;
        logic conv_b;
        logic res_load;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic hold;
        logic wrap;
    } sts_t;

    // Divide by 32 rounding toward zero, add the screen centre and clamp.
    function automatic logic [ROW_W-1:0] to_row(input logic signed [SAMPLE_W-1:0] s);
        logic signed [SAMPLE_W:0] t;
        logic signed [SAMPLE_W:0] v;
        begin
            t = {s[SAMPLE_W-1], s} + (s[SAMPLE_W-1] ? (SAMPLE_W+1)'(DIV_ROUND)
                                                    : (SAMPLE_W+1)'(0));
            v = (t >>> DIV_SHIFT) + (SAMPLE_W+1)'(ROW_OFFSET);
            if (v < 0)
            begin
                v = '0;
            end
            else if (v > (SAMPLE_W+1)'(ROW_MAX))
            begin
                v = (SAMPLE_W+1)'(ROW_MAX);
            end
            to_row = v[ROW_W-1:0];
        end
    endfunction

endpackage
`default_nettype wire

FILE: design/scope_capture_column_render_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scope_capture_column_render_unit: oscilloscope capture and column renderer
// Captures signed samples into a ring and answers column queries with the
// vertical span of the trace between two neighbouring samples.
// ----------------------------------------------------------------------------
// After reset the block clears all RING_DEPTH entries of its sample memory
// (512 by default), one entry a cycle; in_ready stays low during that pass.
// Sample, begin-hold and end-hold requests then complete in the idle state,
// which stays ready. A column query keeps in_ready low until its result is
// loaded. When the look-back wraps past index zero, the wrapped index goes
// through an 8-step bit-serial remainder unit first; the two samples are read
// one after the other through the single memory read port. A finished span
// sits in the output register, and a further query waits at its end until
// that register has been emptied. The length register may only be written
// while no query is in progress.
module scope_capture_column_render_unit #(
    parameter int RING_DEPTH = 512
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [sccr_pkg::CFG_W-1:0]            cfg_wr_data,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [1:0]                            req_type,
    input  wire logic signed [sccr_pkg::SAMPLE_W-1:0]  sample,
    input  wire logic [sccr_pkg::COL_W-1:0]            column,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic [sccr_pkg::ROW_W-1:0]                 row_low,
    output logic [sccr_pkg::ROW_W-1:0]                 row_high
);

    sccr_pkg::cmd_t cmd;
    sccr_pkg::sts_t sts;

    sccr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    sccr_datapath #(
        .RING_DEPTH (RING_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .sample      (sample),
        .column      (column),
        .row_low     (row_low),
        .row_high    (row_high),
        .cmd         (cmd),
        .sts         (sts)
    );

`ifndef SYNTHESIS
    // A presented span is ordered and lies on the screen.
    a_span_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (row_low <= row_high) &&
                      (row_high <= sccr_pkg::ROW_W'(sccr_pkg::ROW_MAX)))
        else $error("span out of order or off screen");

    // A query keeps the block busy for the cycle after its transfer.
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (req_type == sccr_pkg::REQ_QUERY)) |=> !in_ready)
        else $error("request taken while a query is in progress");

    // Loading a result always presents it on the output channel.
    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |=> out_valid)
        else $error("result loaded but not presented");
`endif

endmodule
`default_nettype wire

FILE: design/sccr_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sccr_ctrl: sequencing controller
// Runs the clearing pass after reset, decodes accepted requests and steps a
// column query through remainder, address, read, conversion and result.
// ----------------------------------------------------------------------------
module sccr_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [1:0]    req_type,
    output logic               out_valid,
    input  wire logic          out_ready,
    output sccr_pkg::cmd_t     cmd,
    input  wire sccr_pkg::sts_t sts
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_ADDR,
        ST_RD_A,
        ST_RD_B,
        ST_CONV,
        ST_DONE
    } state_t;

    localparam int STEP_W = $clog2(sccr_pkg::MOD_STEPS);

    state_t              state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                out_valid_reg, out_valid_next;
    logic                acc;

    assign in_ready  = (state_reg == ST_IDLE);
    assign acc       = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (acc)
                begin
                    case (sccr_pkg::req_type_t'(req_type))
                        sccr_pkg::REQ_SAMPLE:     cmd.smp_wr   = !sts.hold;
                        sccr_pkg::REQ_HOLD_BEGIN: cmd.set_hold = 1'b1;
                        sccr_pkg::REQ_HOLD_END:   cmd.clr_hold = 1'b1;
                        sccr_pkg::REQ_QUERY:
                        begin
                            cmd.q_load = 1'b1;
                            step_next  = '0;
                            state_next = ST_MOD;
                        end
                        default: cmd = '0;
                    endcase
                end
            end
            ST_MOD:
            begin
                // The remainder unit only runs when the look-back passes zero.
                if (!sts.wrap)
                begin
                    state_next = ST_ADDR;
                end
                else
                begin
                    cmd.mod_step = 1'b1;
                    step_next    = step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(sccr_pkg::MOD_STEPS - 1))
                    begin
                        state_next = ST_ADDR;
                    end
                end
            end
            ST_ADDR:
            begin
                cmd.addr_calc = 1'b1;
                state_next    = ST_RD_A;
            end
            ST_RD_A:
            begin
                cmd.rd_start = 1'b1;
                state_next   = ST_RD_B;
            end
            ST_RD_B:
            begin
                cmd.rd_stop = 1'b1;
                state_next  = ST_CONV;
            end
            ST_CONV:
            begin
                cmd.conv_b = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

FILE: design/sccr_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sccr_datapath: sample ring and query datapath
// Holds the sample memory, head pointer, hold flag and length register, the
// bit-serial remainder unit for wrapped look-backs and the row conversion.
// ----------------------------------------------------------------------------
module sccr_datapath #(
    parameter int RING_DEPTH = 512
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [sccr_pkg::CFG_W-1:0]            cfg_wr_data,
    input  wire logic signed [sccr_pkg::SAMPLE_W-1:0]  sample,
    input  wire logic [sccr_pkg::COL_W-1:0]            column,
    output logic [sccr_pkg::ROW_W-1:0]                 row_low,
    output logic [sccr_pkg::ROW_W-1:0]                 row_high,
    input  wire sccr_pkg::cmd_t                        cmd,
    output sccr_pkg::sts_t                             sts
);

    localparam int HEAD_W = $clog2(RING_DEPTH);
    localparam int LEN_W  = $clog2(RING_DEPTH + 1);
    localparam int CMP_W  = ((LEN_W > sccr_pkg::CFG_W) ? LEN_W : sccr_pkg::CFG_W) + 1;
    localparam int CW     = (HEAD_W > sccr_pkg::COL_W) ? HEAD_W : sccr_pkg::COL_W;
    localparam int COL_W  = sccr_pkg::COL_W;
    localparam int ROW_W  = sccr_pkg::ROW_W;

    logic signed [sccr_pkg::SAMPLE_W-1:0] sample_ring_reg [RING_DEPTH];

    logic [sccr_pkg::CFG_W-1:0] buffer_length_reg;
    logic [HEAD_W-1:0]          head_reg, head_next;
    logic                       hold_reg;
    logic [HEAD_W-1:0]          clr_addr_reg;

    logic                       wrap_reg;
    logic [COL_W-1:0]           divd_reg;
    logic [HEAD_W-1:0]          fwd_reg;
    logic [LEN_W-1:0]           rem_reg, rem_next;
    logic [HEAD_W-1:0]          start_reg, start_next;
    logic [HEAD_W-1:0]          stop_reg, stop_next;
    logic signed [sccr_pkg::SAMPLE_W-1:0] rd_data_reg;
    logic [ROW_W-1:0]           row_a_reg, row_b_reg;
    logic [ROW_W-1:0]           row_low_reg, row_high_reg;

    logic [CMP_W-1:0]           bl_ext;
    logic [CMP_W-1:0]           len_wide;
    logic [LEN_W-1:0]           eff_len;
    logic [LEN_W-1:0]           eff_len_m1;
    logic [LEN_W-1:0]           head_inc;
    logic [CW-1:0]              head_ext, col_ext, diff_back, diff_fwd;
    logic [LEN_W:0]             trial, trial_sub;
    logic [LEN_W-1:0]           start_w;

    // Effective ring length: the register clamped to two and to the depth.
    always_comb
    begin
        bl_ext = CMP_W'(buffer_length_reg);
        if (bl_ext < CMP_W'(2))
        begin
            len_wide = CMP_W'(2);
        end
        else if (bl_ext > CMP_W'(RING_DEPTH))
        begin
            len_wide = CMP_W'(RING_DEPTH);
        end
        else
        begin
            len_wide = bl_ext;
        end
        eff_len    = len_wide[LEN_W-1:0];
        eff_len_m1 = eff_len - LEN_W'(1);
    end

    always_comb
    begin
        head_inc = LEN_W'(head_reg) + LEN_W'(1);
        if (head_inc >= eff_len)
        begin
            head_next = '0;
        end
        else
        begin
            head_next = head_inc[HEAD_W-1:0];
        end
    end

    assign head_ext  = CW'(head_reg);
    assign col_ext   = CW'(column);
    assign diff_back = col_ext - head_ext;
    assign diff_fwd  = head_ext - col_ext;

    // One restoring remainder step: bring in the next dividend bit.
    always_comb
    begin
        trial     = {rem_reg, divd_reg[COL_W-1]};
        trial_sub = trial - {1'b0, eff_len};
        if (trial >= {1'b0, eff_len})
        begin
            rem_next = trial_sub[LEN_W-1:0];
        end
        else
        begin
            rem_next = trial[LEN_W-1:0];
        end
    end

    always_comb
    begin
        if (!wrap_reg)
        begin
            start_w = LEN_W'(fwd_reg);
        end
        else if (rem_reg != '0)
        begin
            start_w = eff_len - rem_reg;
        end
        else
        begin
            start_w = '0;
        end
        start_next = start_w[HEAD_W-1:0];
        if (start_next == '0)
        begin
            stop_next = eff_len_m1[HEAD_W-1:0];
        end
        else
        begin
            stop_next = start_next - HEAD_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buffer_length_reg <= sccr_pkg::CFG_W'(sccr_pkg::LENGTH_RESET);
            head_reg          <= '0;
            hold_reg          <= 1'b0;
            clr_addr_reg      <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                buffer_length_reg <= cfg_wr_data;
            end
            if (cmd.smp_wr)
            begin
                head_reg <= head_next;
            end
            if (cmd.set_hold)
            begin
                hold_reg <= 1'b1;
            end
            else if (cmd.clr_hold)
            begin
                hold_reg <= 1'b0;
            end
            if (cmd.clr_wr)
            begin
                clr_addr_reg <= clr_addr_reg + HEAD_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.q_load)
        begin
            wrap_reg <= (head_ext < col_ext);
            divd_reg <= diff_back[COL_W-1:0];
            fwd_reg  <= diff_fwd[HEAD_W-1:0];
            rem_reg  <= '0;
        end
        else if (cmd.mod_step)
        begin
            rem_reg  <= rem_next;
            divd_reg <= {divd_reg[COL_W-2:0], 1'b0};
        end
        if (cmd.addr_calc)
        begin
            start_reg <= start_next;
            stop_reg  <= stop_next;
        end
        if (cmd.rd_stop)
        begin
            row_a_reg <= sccr_pkg::to_row(rd_data_reg);
        end
        if (cmd.conv_b)
        begin
            row_b_reg <= sccr_pkg::to_row(rd_data_reg);
        end
        if (cmd.res_load)
        begin
            if (row_a_reg > row_b_reg)
            begin
                row_low_reg  <= row_b_reg;
                row_high_reg <= row_a_reg;
            end
            else
            begin
                row_low_reg  <= row_a_reg;
                row_high_reg <= row_b_reg;
            end
        end
    end

    // Sample memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.clr_wr)
        begin
            sample_ring_reg[clr_addr_reg] <= '0;
        end
        else if (cmd.smp_wr)
        begin
            sample_ring_reg[head_next] <= sample;
        end
        if (cmd.rd_start)
        begin
            rd_data_reg <= sample_ring_reg[start_reg];
        end
        else if (cmd.rd_stop)
        begin
            rd_data_reg <= sample_ring_reg[stop_reg];
        end
    end

    assign sts.clr_last = (clr_addr_reg == HEAD_W'(RING_DEPTH - 1));
    assign sts.hold     = hold_reg;
    assign sts.wrap     = wrap_reg;
    assign row_low      = row_low_reg;
    assign row_high     = row_high_reg;

endmodule
`default_nettype wire

FILE: sim/tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb: testbench for the scope capture column renderer
// Drives sample, hold and column requests through the valid/ready input
// channel and predicts each column span from a model of the capture ring.
// Every span that leaves the block is checked against the oldest prediction.
// The ring length register is swept through several values, the extremes
// among them.
// ----------------------------------------------------------------------------
module tb;

    localparam int RING_DEPTH = 512;
    localparam int PHASE_ITEMS = 70;
    localparam int SETTLE_CYCLES = 24;

    typedef struct {
        sccr_pkg::req_type_t kind;
        logic signed [15:0]  smp;
        logic [7:0]          col;
    } scope_req_t;

    typedef struct {
        logic [7:0] lo;
        logic [7:0] hi;
    } span_t;

    logic                                  clk;
    logic                                  rst_n;
    logic                                  cfg_wr_en;
    logic [sccr_pkg::CFG_W-1:0]            cfg_wr_data;
    logic                                  in_valid;
    logic                                  in_ready;
    logic [1:0]                            req_type;
    logic signed [sccr_pkg::SAMPLE_W-1:0]  sample;
    logic [sccr_pkg::COL_W-1:0]            column;
    logic                                  out_valid;
    logic                                  out_ready;
    logic [sccr_pkg::ROW_W-1:0]            row_low;
    logic [sccr_pkg::ROW_W-1:0]            row_high;

    scope_req_t pending_reqs[$];
    span_t      expected_spans[$];

    // Predicted state of the capture ring.
    logic signed [15:0]          ring_mem [RING_DEPTH];
    int unsigned                 head_pos;
    bit                          held;
    logic [sccr_pkg::CFG_W-1:0]  len_reg;

    int  errors;
    bit  in_taken;
    bit  steady;
    int  in_gap;
    int  stall_left;

    scope_capture_column_render_unit #(
        .RING_DEPTH(RING_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .req_type(req_type),
        .sample(sample),
        .column(column),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .row_low(row_low),
        .row_high(row_high)
    );

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        in_valid = 1'b0;
        req_type = sccr_pkg::REQ_SAMPLE;
        sample = '0;
        column = '0;
        out_ready = 1'b0;
        errors = 0;
        in_taken = 1'b0;
        steady = 1'b0;
        in_gap = 0;
        stall_left = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("tb: errors");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        begin
            $display("tb mismatch: %s", msg);
            errors++;
        end
    endtask

    function automatic int unsigned ring_len();
        int unsigned n;
        begin
            n = 32'(len_reg);
            if (n < 2)
            begin
                n = 2;
            end
            if (n > RING_DEPTH)
            begin
                n = RING_DEPTH;
            end
            return n;
        end
    endfunction

    // Integer division in SystemVerilog truncates toward zero, as required.
    function automatic logic [7:0] row_of(input logic signed [15:0] s);
        int v;
        begin
            v = int'(s) / 32 + sccr_pkg::ROW_OFFSET;
            if (v < 0)
            begin
                v = 0;
            end
            if (v > sccr_pkg::ROW_MAX)
            begin
                v = sccr_pkg::ROW_MAX;
            end
            return v[7:0];
        end
    endfunction

    task automatic apply_request(input scope_req_t r);
        int unsigned len;
        int unsigned nxt;
        int unsigned start;
        int unsigned stop;
        int unsigned rem;
        int unsigned col;
        span_t       s;
        logic [7:0]  a;
        logic [7:0]  b;
        begin
            len = ring_len();
            col = 32'(r.col);
            case (r.kind)
                sccr_pkg::REQ_SAMPLE:
                begin
                    if (!held)
                    begin
                        nxt = head_pos + 1;
                        if (nxt >= len)
                        begin
                            nxt = 0;
                        end
                        head_pos = nxt;
                        ring_mem[nxt % RING_DEPTH] = r.smp;
                    end
                end
                sccr_pkg::REQ_HOLD_BEGIN:
                begin
                    held = 1'b1;
                end
                sccr_pkg::REQ_HOLD_END:
                begin
                    held = 1'b0;
                end
                default:
                begin
                    // A look-back past index zero wraps modulo the ring length;
                    // a stale head above the length is used as it stands.
                    if (head_pos >= col)
                    begin
                        start = head_pos - col;
                    end
                    else
                    begin
                        rem = (col - head_pos) % len;
                        start = (rem != 0) ? len - rem : 0;
                    end
                    stop = (start == 0) ? len - 1 : start - 1;
                    a = row_of(ring_mem[start % RING_DEPTH]);
                    b = row_of(ring_mem[stop % RING_DEPTH]);
                    s.lo = (a > b) ? b : a;
                    s.hi = (a > b) ? a : b;
                    expected_spans.push_back(s);
                end
            endcase
        end
    endtask

    // Predictor and checker: transfers are sampled at the rising edge.
    always @(posedge clk)
    begin
        span_t want;
        scope_req_t r;
        if (!rst_n)
        begin
            for (int i = 0; i < RING_DEPTH; i++)
            begin
                ring_mem[i] = '0;
            end
            head_pos = 0;
            held = 1'b0;
            len_reg = sccr_pkg::CFG_W'(sccr_pkg::LENGTH_RESET);
            in_taken = 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                len_reg = cfg_wr_data;
            end
            if (out_valid && out_ready)
            begin
                if (expected_spans.size() == 0)
                begin
                    report_mismatch($sformatf("span %0d..%0d with none expected",
                                              row_low, row_high));
                end
                else
                begin
                    want = expected_spans.pop_front();
                    if (row_low !== want.lo)
                    begin
                        report_mismatch($sformatf("row_low got %0d, expected %0d",
                                                  row_low, want.lo));
                    end
                    if (row_high !== want.hi)
                    begin
                        report_mismatch($sformatf("row_high got %0d, expected %0d",
                                                  row_high, want.hi));
                    end
                end
            end
            in_taken = in_valid && in_ready;
            if (in_taken)
            begin
                r.kind = sccr_pkg::req_type_t'(req_type);
                r.smp = sample;
                r.col = column;
                apply_request(r);
            end
        end
    end

    // Request driver: a new item goes out once the previous transfer is done.
    always @(negedge clk)
    begin
        scope_req_t r;
        if (rst_n && (!in_valid || in_taken))
        begin
            if (in_gap > 0)
            begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                r = pending_reqs.pop_front();
                in_valid <= 1'b1;
                req_type <= r.kind;
                sample <= r.smp;
                column <= r.col;
                if (!steady && $urandom_range(0, 5) == 0)
                begin
                    in_gap = $urandom_range(1, 8);
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result side back-pressure.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!steady && $urandom_range(0, 5) == 0)
                begin
                    stall_left = $urandom_range(1, 8);
                end
            end
        end
    end

    task automatic queue_request(input sccr_pkg::req_type_t kind, input int smp,
                                 input int col);
        scope_req_t r;
        begin
            r.kind = kind;
            r.smp = smp[15:0];
            r.col = col[7:0];
            pending_reqs.push_back(r);
        end
    endtask

    function automatic scope_req_t random_request();
        scope_req_t r;
        int         pick;
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                r.kind = sccr_pkg::REQ_SAMPLE;
            end
            else if (pick < 85)
            begin
                r.kind = sccr_pkg::REQ_QUERY;
            end
            else if (pick < 91)
            begin
                r.kind = sccr_pkg::REQ_HOLD_BEGIN;
            end
            else
            begin
                r.kind = sccr_pkg::REQ_HOLD_END;
            end
            if ($urandom_range(0, 1) == 0)
            begin
                r.smp = 16'($urandom_range(0, 65535));
            end
            else
            begin
                r.smp = 16'($signed($urandom_range(0, 16000)) - 8000);
            end
            r.col = 8'(($urandom_range(0, 7) == 0) ? $urandom_range(240, 255)
                                                   : $urandom_range(0, 239));
            return r;
        end
    endfunction

    task automatic queue_random(input int count);
        begin
            for (int i = 0; i < count; i++)
            begin
                pending_reqs.push_back(random_request());
            end
        end
    endtask

    // The sender stays quiet until every span has arrived and the block has
    // had time to finish a request that yields no result.
    task automatic drain_phase();
        begin
            @(posedge clk);
            while (pending_reqs.size() != 0 || in_valid || expected_spans.size() != 0)
            begin
                @(posedge clk);
            end
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
    endtask

    task automatic write_length(input logic [sccr_pkg::CFG_W-1:0] value);
        begin
            @(negedge clk);
            cfg_wr_en <= 1'b1;
            cfg_wr_data <= value;
            @(negedge clk);
            cfg_wr_en <= 1'b0;
            @(posedge clk);
        end
    endtask

    initial
    begin
        logic [sccr_pkg::CFG_W-1:0] lengths [14];
        lengths = '{10'd3, 10'd2, 10'd0, 10'd1, 10'd1023, 10'd5, 10'd512,
                    10'd513, 10'd97, 10'd240, 10'd241, 10'd16, 10'd2, 10'd512};
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        // Wait for the clearing pass over the sample memory to finish.
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end

        // Directed items at the reset length.
        queue_request(sccr_pkg::REQ_QUERY, 0, 0);
        queue_request(sccr_pkg::REQ_QUERY, 0, 255);
        queue_request(sccr_pkg::REQ_SAMPLE, 32767, 0);
        queue_request(sccr_pkg::REQ_SAMPLE, -32768, 0);
        queue_request(sccr_pkg::REQ_QUERY, 0, 0);
        queue_request(sccr_pkg::REQ_SAMPLE, -31, 0);
        queue_request(sccr_pkg::REQ_SAMPLE, -32, 0);
        queue_request(sccr_pkg::REQ_QUERY, 0, 0);
        queue_request(sccr_pkg::REQ_SAMPLE, 31, 0);
        queue_request(sccr_pkg::REQ_SAMPLE, 32, 0);
        queue_request(sccr_pkg::REQ_QUERY, 0, 0);
        queue_request(sccr_pkg::REQ_SAMPLE, 3840, 0);
        queue_request(sccr_pkg::REQ_SAMPLE, -3872, 0);
        queue_request(sccr_pkg::REQ_QUERY, 0, 0);
        queue_request(sccr_pkg::REQ_SAMPLE, -3841, 0);
        queue_request(sccr_pkg::REQ_SAMPLE, 3808, 0);
        queue_request(sccr_pkg::REQ_QUERY, 0, 1);
        // A sample during hold is dropped, and a query is still answered.
        queue_request(sccr_pkg::REQ_HOLD_BEGIN, 0, 0);
        queue_request(sccr_pkg::REQ_SAMPLE, 1234, 0);
        queue_request(sccr_pkg::REQ_QUERY, 0, 0);
        queue_request(sccr_pkg::REQ_HOLD_END, 0, 0);
        queue_request(sccr_pkg::REQ_QUERY, 0, 239);
        queue_request(sccr_pkg::REQ_QUERY, 0, 240);
        queue_request(sccr_pkg::REQ_QUERY, 0, 10);
        queue_request(sccr_pkg::REQ_QUERY, 0, 11);
        queue_random(60);
        drain_phase();

        for (int p = 0; p < 14; p++)
        begin
            if (p >= 12)
            begin
                steady = 1'b1;
            end
            write_length(lengths[p]);
            queue_random(PHASE_ITEMS);
            drain_phase();
        end

        if (errors == 0)
        begin
            $display("tb: clean");
        end
        else
        begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
`default_nettype wire

FILE: filelist.f
design/sccr_pkg.sv
design/sccr_ctrl.sv
design/sccr_datapath.sv
design/scope_capture_column_render_unit.sv
sim/tb.sv
